@@ sv/event_flag_group_waiters_defines.svh @@
// Assertion macros for the event flag group block.
// No dependencies; included by efg_dp, the module that carries assertions.
`ifndef EVENT_FLAG_GROUP_WAITERS_DEFINES_SVH
`define EVENT_FLAG_GROUP_WAITERS_DEFINES_SVH

// Implication checked every cycle outside reset.
`define EFG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define EFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/efg_pkg.sv @@
// Shared types and constants of the event flag group block.
// No dependencies.
package efg_pkg;

  localparam int unsigned WAITERS_DEF   = 8;
  localparam int unsigned FLAG_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_REINIT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_OK     = 3'd0,
    KIND_AGAIN  = 3'd1,
    KIND_QUEUED = 3'd2,
    KIND_WOKEN  = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_FULL   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET_UPD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  waiter_id;
    logic [7:0]  waiter_prio;
    logic        wait_all;
    logic        clear_on_exit;
    logic [15:0] wanted_flags;
    logic        can_wait;
    logic [15:0] set_value;
    logic [15:0] set_mask;
    logic [7:0]  running_prio;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  woken_id;
    logic [15:0] result_flags;
    logic        sched_needed;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;
    logic wait_go;
    logic reinit;
    logic set_upd;
    logic scan_step;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } status_t;

endpackage

@@ sv/event_flag_group_waiters.sv @@
// Event flag group with an ordered queue of waiters.
// Wait items: result the next cycle; reinit items give no result; a new item each cycle while busy is low.
// Set item: update, one scan step per queued waiter, then done; busy meanwhile.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous active-low reset clears the flag word, queue count and the initial word init_r.
// Top level; depends on efg_pkg, efg_ctrl and efg_dp.
module event_flag_group_waiters #(
  parameter int unsigned WAITERS   = efg_pkg::WAITERS_DEF,
  parameter int unsigned FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  efg_pkg::in_t   in_data,
  output logic           out_valid,
  output efg_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  efg_pkg::cmd_t    cmd;
  efg_pkg::status_t st;

  assign cfg_ready = 1'b1;

  efg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  efg_dp #(
    .WAITERS   (WAITERS),
    .FLAG_BITS (FLAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/efg_ctrl.sv @@
// Sequencer of the event flag group: decodes items and steps the waiter scan.
// Depends on efg_pkg.
module efg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        mode,
  input  efg_pkg::status_t  st,
  output efg_pkg::cmd_t     cmd,
  output logic              busy
);

  efg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efg_pkg::ST_IDLE: begin
        if (start && mode == efg_pkg::MODE_SET) state_nxt = efg_pkg::ST_SET_UPD;
      end
      efg_pkg::ST_SET_UPD: begin
        state_nxt = st.cnt_zero ? efg_pkg::ST_DONE : efg_pkg::ST_SCAN;
      end
      efg_pkg::ST_SCAN: begin
        if (st.scan_last) state_nxt = efg_pkg::ST_DONE;
      end
      efg_pkg::ST_DONE: begin
        state_nxt = efg_pkg::ST_IDLE;
      end
      default: state_nxt = efg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      efg_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.wait_go = start && mode == efg_pkg::MODE_WAIT;
        cmd.load    = start && mode == efg_pkg::MODE_SET;
        cmd.reinit  = start && mode == efg_pkg::MODE_REINIT;
      end
      efg_pkg::ST_SET_UPD: cmd.set_upd   = 1'b1;
      efg_pkg::ST_SCAN:    cmd.scan_step = 1'b1;
      efg_pkg::ST_DONE:    cmd.done      = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/efg_dp.sv @@
// Datapath of the event flag group: flag word, ordered waiter queue, results.
// Depends on efg_pkg and event_flag_group_waiters_defines.svh.
`include "event_flag_group_waiters_defines.svh"
module efg_dp #(
  parameter int unsigned WAITERS   = efg_pkg::WAITERS_DEF,
  parameter int unsigned FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  efg_pkg::in_t      in_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  efg_pkg::cmd_t     cmd,
  output efg_pkg::status_t  st,
  output logic              out_valid,
  output efg_pkg::out_t     out_data
);

  localparam int unsigned CW = $clog2(WAITERS + 1);
  localparam int unsigned IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int unsigned FB = FLAG_BITS;

  logic [15:0]   init_r;
  logic [FB-1:0] flag_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] rem_r;
  logic [FB-1:0] acc_r;
  logic          sched_r;
  efg_pkg::in_t  item_r;

  logic [FB-1:0] wanted_r [WAITERS];
  logic          all_r    [WAITERS];
  logic          clr_r    [WAITERS];
  logic [7:0]    tag_r    [WAITERS];
  logic [7:0]    prio_r   [WAITERS];

  logic          out_valid_r;
  efg_pkg::out_t out_r;

  function automatic logic [FB-1:0] match(input logic [FB-1:0] w, input logic [FB-1:0] want,
                                          input logic all);
    logic [FB-1:0] m;
    m = w & want;
    if (all && m != want) m = '0;
    return m;
  endfunction

  logic [FB-1:0] in_want, wait_m, set_val, set_msk, head_m;
  logic          head_hit, head_sched, full;

  assign in_want    = FB'(in_data.wanted_flags);
  assign wait_m     = match(flag_r, in_want, in_data.wait_all);
  assign full       = cnt_r == CW'(WAITERS);
  assign set_val    = FB'(item_r.set_value);
  assign set_msk    = FB'(item_r.set_mask);
  assign head_m     = match(flag_r, wanted_r[0], all_r[0]);
  assign head_hit   = head_m != '0;
  assign head_sched = prio_r[0] > item_r.running_prio;

  assign st.cnt_zero  = cnt_r == '0;
  assign st.scan_last = rem_r == CW'(1);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= '0;
      flag_r      <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) init_r <= cfg_data;
      out_valid_r <= cmd.wait_go || (cmd.scan_step && head_hit) || cmd.done;
      if (cmd.reinit) begin
        flag_r <= FB'(init_r);
        cnt_r  <= '0;
      end
      if (cmd.wait_go && wait_m == '0 && in_data.can_wait && !full) cnt_r <= cnt_r + CW'(1);
      if (cmd.set_upd) begin
        flag_r <= flag_r ^ ((flag_r ^ set_val) & set_msk);
        rem_r  <= cnt_r;
      end
      if (cmd.scan_step) begin
        rem_r <= rem_r - CW'(1);
        if (head_hit) cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.done) flag_r <= flag_r & ~acc_r;
    end
  end

  // payload: queue entries, accumulators, result register
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.set_upd) begin
      acc_r   <= '0;
      sched_r <= 1'b0;
    end
    if (cmd.wait_go && wait_m == '0 && in_data.can_wait && !full) begin
      wanted_r[cnt_r[IW-1:0]] <= in_want;
      all_r[cnt_r[IW-1:0]]    <= in_data.wait_all;
      clr_r[cnt_r[IW-1:0]]    <= in_data.clear_on_exit;
      tag_r[cnt_r[IW-1:0]]    <= in_data.waiter_id;
      prio_r[cnt_r[IW-1:0]]   <= in_data.waiter_prio;
    end
    if (cmd.scan_step) begin
      // pop the head; a miss goes back to the tail so order is kept
      for (int j = 0; j + 1 < WAITERS; j++) begin
        wanted_r[j] <= wanted_r[j+1];
        all_r[j]    <= all_r[j+1];
        clr_r[j]    <= clr_r[j+1];
        tag_r[j]    <= tag_r[j+1];
        prio_r[j]   <= prio_r[j+1];
      end
      if (head_hit) begin
        if (clr_r[0]) acc_r <= acc_r | head_m;
        if (head_sched) sched_r <= 1'b1;
      end else begin
        wanted_r[IW'(cnt_r - CW'(1))] <= wanted_r[0];
        all_r[IW'(cnt_r - CW'(1))]    <= all_r[0];
        clr_r[IW'(cnt_r - CW'(1))]    <= clr_r[0];
        tag_r[IW'(cnt_r - CW'(1))]    <= tag_r[0];
        prio_r[IW'(cnt_r - CW'(1))]   <= prio_r[0];
      end
    end

    out_r <= '0;
    if (cmd.wait_go) begin
      out_r.woken_id <= in_data.waiter_id;
      out_r.last     <= 1'b1;
      if (wait_m != '0) begin
        out_r.kind         <= efg_pkg::KIND_OK;
        out_r.result_flags <= 16'(wait_m);
      end else if (!in_data.can_wait) begin
        out_r.kind <= efg_pkg::KIND_AGAIN;
      end else if (full) begin
        out_r.kind <= efg_pkg::KIND_FULL;
      end else begin
        out_r.kind <= efg_pkg::KIND_QUEUED;
      end
    end else if (cmd.scan_step) begin
      out_r.kind         <= efg_pkg::KIND_WOKEN;
      out_r.woken_id     <= tag_r[0];
      out_r.result_flags <= 16'(head_m);
      out_r.sched_needed <= head_sched;
    end else if (cmd.done) begin
      out_r.kind         <= efg_pkg::KIND_DONE;
      out_r.sched_needed <= sched_r;
      out_r.last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `EFG_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(WAITERS), "queue count overflow")
  `EFG_ASSERT_NEXT(a_reinit_empty, clk, rst_n, cmd.reinit, cnt_r == '0, "reinit left waiters")
  `EFG_ASSERT_NEXT(a_done_last, clk, rst_n, cmd.done, out_valid_r && out_r.last, "done not last")
  `EFG_ASSERT_IMP(a_woken_not_last, clk, rst_n,
                  out_valid_r && out_r.kind == efg_pkg::KIND_WOKEN, !out_r.last,
                  "woken result marked last")

endmodule

@@ tb/efg_checker.sv @@
// Scoreboard for the event flag group: watches the command, result and config
// transfers, predicts results and compares them. Depends on efg_pkg.
`timescale 1ns / 1ps
module efg_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  efg_pkg::in_t  in_data,
  input  logic          out_valid,
  input  efg_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  output int            fail_count,
  output int            pending
);
  import efg_pkg::*;

  localparam int NSLOT = 8;

  logic [15:0] init_word;
  logic [15:0] flags;
  logic        q_valid [NSLOT];
  logic [15:0] q_wanted [NSLOT];
  logic        q_all [NSLOT];
  logic        q_clr [NSLOT];
  logic [7:0]  q_tag [NSLOT];
  logic [7:0]  q_prio [NSLOT];
  out_t        expected_q[$];

  function automatic logic [15:0] matched(logic [15:0] w, logic [15:0] want, logic all);
    logic [15:0] r;
    r = w & want;
    if (all && r != want) r = '0;
    return r;
  endfunction

  function automatic out_t mk(kind_t k, logic [7:0] id, logic [15:0] f, logic s, logic l);
    out_t o;
    o.kind = k;
    o.woken_id = id;
    o.result_flags = f;
    o.sched_needed = s;
    o.last = l;
    return o;
  endfunction

  task automatic predict_item(in_t it);
    logic [15:0] r;
    logic [15:0] acc;
    logic        any_s;
    logic        s;
    int          fs;
    int          i;
    acc = '0;
    any_s = 0;
    fs = -1;
    i = 0;
    case (mode_t'(it.mode))
      MODE_WAIT: begin
        r = matched(flags, it.wanted_flags, it.wait_all);
        if (r != 0) expected_q.push_back(mk(KIND_OK, it.waiter_id, r, 0, 1));
        else if (!it.can_wait) expected_q.push_back(mk(KIND_AGAIN, it.waiter_id, 0, 0, 1));
        else begin
          for (int k = NSLOT - 1; k >= 0; k--) if (!q_valid[k]) fs = k;
          if (fs < 0) expected_q.push_back(mk(KIND_FULL, it.waiter_id, 0, 0, 1));
          else begin
            q_valid[fs] = 1;
            q_wanted[fs] = it.wanted_flags;
            q_all[fs] = it.wait_all;
            q_clr[fs] = it.clear_on_exit;
            q_tag[fs] = it.waiter_id;
            q_prio[fs] = it.waiter_prio;
            expected_q.push_back(mk(KIND_QUEUED, it.waiter_id, 0, 0, 1));
          end
        end
      end
      MODE_SET: begin
        flags = flags ^ ((flags ^ it.set_value) & it.set_mask);
        while (i < NSLOT && q_valid[i]) begin
          r = matched(flags, q_wanted[i], q_all[i]);
          if (r != 0) begin
            s = q_prio[i] > it.running_prio;
            if (q_clr[i]) acc |= r;
            any_s |= s;
            expected_q.push_back(mk(KIND_WOKEN, q_tag[i], r, s, 0));
            // close the gap so arrival order holds
            for (int j = i; j < NSLOT - 1; j++) begin
              q_valid[j] = q_valid[j+1];
              q_wanted[j] = q_wanted[j+1];
              q_all[j] = q_all[j+1];
              q_clr[j] = q_clr[j+1];
              q_tag[j] = q_tag[j+1];
              q_prio[j] = q_prio[j+1];
            end
            q_valid[NSLOT-1] = 0;
          end else i++;
        end
        flags &= ~acc;
        expected_q.push_back(mk(KIND_DONE, 0, 0, any_s, 1));
      end
      MODE_REINIT: begin
        flags = init_word;
        for (int k = 0; k < NSLOT; k++) q_valid[k] = 0;
      end
      default: ;
    endcase
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      init_word <= '0;
      flags = '0;
      for (int k = 0; k < NSLOT; k++) q_valid[k] = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data != e) begin
            if (out_data.kind != e.kind)
              $error("kind: expected %0d, got %0d", e.kind, out_data.kind);
            if (out_data.woken_id != e.woken_id)
              $error("woken_id: expected %0d, got %0d", e.woken_id, out_data.woken_id);
            if (out_data.result_flags != e.result_flags)
              $error("result_flags: expected %h, got %h", e.result_flags,
                     out_data.result_flags);
            if (out_data.sched_needed != e.sched_needed)
              $error("sched_needed: expected %0d, got %0d", e.sched_needed,
                     out_data.sched_needed);
            if (out_data.last != e.last)
              $error("last: expected %0d, got %0d", e.last, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_item(in_data);
      if (cfg_valid && cfg_ready) init_word <= cfg_data;
    end
  end
endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, stimulus and verdict for event_flag_group_waiters.
// Depends on efg_pkg, the block and efg_checker.
`timescale 1ns / 1ps
module tb_top;
  import efg_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  event_flag_group_waiters i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  efg_checker i_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one command transfer, after a random gap when gaps is set; start is left high after the transfer
  // so a back-to-back command needs no second update of start in the same step
  task automatic send_cmd(in_t it, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 13) : 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
    start <= 1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_init(logic [15:0] v);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic in_t wait_cmd(logic [7:0] id, logic [7:0] pr, logic all, logic clr,
                                   logic [15:0] want, logic cw);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = MODE_WAIT;
    it.waiter_id = id;
    it.waiter_prio = pr;
    it.wait_all = all;
    it.clear_on_exit = clr;
    it.wanted_flags = want;
    it.can_wait = cw;
    return it;
  endfunction

  function automatic in_t set_cmd(logic [15:0] v, logic [15:0] m, logic [7:0] run);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = MODE_SET;
    it.set_value = v;
    it.set_mask = m;
    it.running_prio = run;
    return it;
  endfunction

  function automatic in_t reinit_cmd(mode_t md);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = md;
    return it;
  endfunction

  // sparse masks make any/all tests pass sometimes but not always
  function automatic logic [15:0] rnd_bits();
    case ($urandom_range(0, 3))
      0: return 16'(1 << $urandom_range(0, 15));
      1: return 16'($urandom) & 16'($urandom) & 16'($urandom);
      2: return 16'($urandom);
      default: return $urandom_range(0, 9) == 0 ? 16'h0000 : 16'hFFFF;
    endcase
  endfunction

  initial begin
    rst_n = 0;
    start = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: immediate, try-again, empty wanted, fill queue, full, wake-ups
    send_cmd(wait_cmd(8'h00, 8'h00, 0, 0, 16'hFFFF, 0), 0);
    send_cmd(wait_cmd(8'hFF, 8'hFF, 1, 1, 16'h0000, 0), 0);
    send_cmd(wait_cmd(8'h01, 8'h00, 0, 0, 16'h0000, 1), 0);
    for (int k = 0; k < 7; k++)
      send_cmd(wait_cmd(8'(8'h10 + k), 8'(k * 40), k[0], k[1], 16'(16'h0003 << k), 1), 0);
    send_cmd(wait_cmd(8'hEE, 8'h80, 0, 1, 16'hFFFF, 1), 0);
    send_cmd(set_cmd(16'hFFFF, 16'hFFFF, 8'h7F), 0);
    send_cmd(wait_cmd(8'h22, 8'hFF, 1, 1, 16'h8001, 1), 1);
    send_cmd(wait_cmd(8'h23, 8'h01, 1, 0, 16'h8001, 0), 0);
    send_cmd(set_cmd(16'h8001, 16'h8001, 8'h00), 0);
    send_cmd(set_cmd(16'h0000, 16'h0000, 8'hFF), 0);
    send_cmd(reinit_cmd(MODE_NONE), 0);
    write_init(16'hFFFF);
    send_cmd(reinit_cmd(MODE_REINIT), 0);
    send_cmd(wait_cmd(8'h30, 8'h10, 1, 1, 16'hFFFF, 1), 0);
    write_init(16'h0000);
    send_cmd(reinit_cmd(MODE_REINIT), 0);

    // random: mostly waits and sets, occasional reinit with a new initial word
    for (int n = 0; n < 230; n++) begin
      bit g;
      g = $urandom_range(0, 3) != 0 || (n / 40) % 2 == 0;
      case ($urandom_range(0, 19))
        0: begin
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 2))
              0: write_init(16'h0000);
              1: write_init(16'hFFFF);
              default: write_init(16'($urandom));
            endcase
          end
          send_cmd(reinit_cmd(MODE_REINIT), g);
        end
        1: send_cmd(reinit_cmd(MODE_NONE), g);
        2, 3, 4, 5, 6, 7:
          send_cmd(set_cmd(rnd_bits(), rnd_bits(), 8'($urandom)), g);
        default:
          send_cmd(wait_cmd(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                            rnd_bits(), $urandom_range(0, 5) != 0), g);
      endcase
    end

    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
